// File: hdl/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// sbfr_pkg
// constants, sequencer states and header pattern of the frame receiver
// ----------------------------------------------------------------------------
package sbfr_pkg;

  localparam int unsigned StoreLen = 18;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned SumW     = 11;

  localparam logic [7:0] SyncByte  = 8'hBB;
  localparam logic [7:0] TypeShort = 8'h05;
  localparam logic [7:0] TypeLong  = 8'h08;
  localparam logic [7:0] TypeDrop  = 8'h00;

  localparam logic [IdxW-1:0] LenShort = IdxW'(15);
  localparam logic [IdxW-1:0] LenLong  = IdxW'(18);
  localparam logic [IdxW-1:0] LenDrop  = IdxW'(10);
  localparam logic [IdxW-1:0] TypePos  = IdxW'(6);
  localparam logic [IdxW-1:0] ZeroPos  = IdxW'(7);
  localparam logic [IdxW-1:0] SumStart = IdxW'(8);
  localparam logic [IdxW-1:0] HdrLen   = IdxW'(6);

  localparam logic [7:0] ResetReload = 8'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } sbfr_state_t;

  function automatic logic [7:0] header_byte(input logic [2:0] pos);
    logic [7:0] v;
    case (pos)
      3'd0:    v = SyncByte;
      3'd2:    v = 8'h06;
      3'd3:    v = 8'h80;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/sync_byte_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_byte_frame_receiver
// a tick or a byte that ends no frame is taken at once, back to back while idle
// a frame-ending byte starts a check pass over all len bytes (15 or 18) through the
// one store read port, then len words go out, one per cycle when out_ready holds
// and no new byte or tick is taken until the last word of the frame has gone out
// rst is synchronous: clears control state and the frame store, reload returns to 8
// ----------------------------------------------------------------------------
module sync_byte_frame_receiver
  import sbfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [4:0] byte_index,
  output logic       last_byte,
  output logic       long_frame,
  output logic       frame_ok,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  sbfr_state_t state, state_next;

  logic [7:0]      store [StoreLen];
  logic [IdxW-1:0] bc, bc_next;
  logic            synced, synced_next;
  logic [7:0]      tc, tc_next;
  logic [7:0]      reload;
  logic [7:0]      prev_byte, prev_byte_next;
  logic            long_sel, long_sel_next;
  logic [IdxW-1:0] k, k_next;
  logic [SumW-1:0] sum, sum_next;
  logic [7:0]      want_lo, want_lo_next;
  logic            ok_acc, ok_acc_next;
  logic            ok_fin, ok_fin_next;
  logic            out_valid_next;
  logic [7:0]      out_byte_next;
  logic [4:0]      byte_index_next;
  logic            last_byte_next;
  logic            long_frame_next;
  logic            frame_ok_next;

  logic            st_we;
  logic            sync_hit;
  logic [IdxW-1:0] bc_mid;
  logic            syn_mid;
  logic [7:0]      tc_mid;
  logic [7:0]      ftype;
  logic            start;
  logic [IdxW-1:0] k_rd;
  logic [7:0]      rd;
  logic [IdxW-1:0] flen;
  logic            chk;

  assign k_rd = (k < IdxW'(StoreLen)) ? k : '0;
  assign rd   = store[k_rd];
  assign flen = long_sel ? LenLong : LenShort;

  always_comb begin
    state_next      = state;
    bc_next         = bc;
    synced_next     = synced;
    tc_next         = tc;
    prev_byte_next  = prev_byte;
    long_sel_next   = long_sel;
    k_next          = k;
    sum_next        = sum;
    want_lo_next    = want_lo;
    ok_acc_next     = ok_acc;
    ok_fin_next     = ok_fin;
    out_valid_next  = out_valid;
    out_byte_next   = out_byte;
    byte_index_next = byte_index;
    last_byte_next  = last_byte;
    long_frame_next = long_frame;
    frame_ok_next   = frame_ok;
    in_ready        = 1'b0;
    st_we           = 1'b0;
    sync_hit        = 1'b0;
    bc_mid          = bc;
    syn_mid         = synced;
    tc_mid          = tc;
    ftype           = store[TypePos];
    start           = 1'b0;
    chk             = 1'b1;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && func) begin
          tc_next = (tc != 8'd0) ? tc - 8'd1 : tc;
        end else if (in_valid) begin
          st_we          = (bc < IdxW'(StoreLen));
          prev_byte_next = rx_byte;
          sync_hit = !synced && (bc != '0) && (bc < IdxW'(StoreLen))
                     && (prev_byte == SyncByte) && (rx_byte == 8'h00);
          bc_mid  = sync_hit ? IdxW'(2) : bc + IdxW'(1);
          tc_mid  = sync_hit ? reload : tc;
          syn_mid = synced | sync_hit;
          ftype   = (bc == TypePos) ? rx_byte : store[TypePos];
          if (ftype == TypeShort && bc_mid >= LenShort) begin
            bc_mid        = '0;
            syn_mid       = 1'b0;
            start         = 1'b1;
            long_sel_next = 1'b0;
          end else if (ftype == TypeLong && bc_mid >= LenLong) begin
            bc_mid        = '0;
            syn_mid       = 1'b0;
            start         = 1'b1;
            long_sel_next = 1'b1;
          end else if (ftype == TypeDrop && bc_mid >= LenDrop) begin
            bc_mid  = '0;
            syn_mid = 1'b0;
          end
          if (bc_mid >= IdxW'(StoreLen) || (bc_mid > IdxW'(2) && tc_mid == 8'd0)) begin
            bc_mid  = '0;
            syn_mid = 1'b0;
          end
          bc_next     = bc_mid;
          synced_next = syn_mid;
          tc_next     = tc_mid;
          if (start) begin
            state_next  = ST_CHECK;
            k_next      = '0;
            sum_next    = '0;
            ok_acc_next = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (k < HdrLen) begin
          chk = (rd == header_byte(k[2:0]));
        end else if (k == ZeroPos) begin
          chk = (rd == 8'h00);
        end
        ok_acc_next = ok_acc & chk;
        if (k >= SumStart && k < flen - IdxW'(2)) begin
          sum_next = sum + SumW'(rd);
        end
        if (k == flen - IdxW'(2)) begin
          want_lo_next = rd;
        end
        if (k == flen - IdxW'(1)) begin
          ok_fin_next = ok_acc & chk & ({5'd0, sum} == {rd, want_lo});
          state_next  = ST_EMIT;
          k_next      = '0;
        end else begin
          k_next = k + IdxW'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          if (k < flen) begin
            out_valid_next  = 1'b1;
            out_byte_next   = rd;
            byte_index_next = k;
            last_byte_next  = (k == flen - IdxW'(1));
            long_frame_next = long_sel;
            frame_ok_next   = ok_fin;
            k_next          = k + IdxW'(1);
          end else begin
            out_valid_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bc        <= '0;
      synced    <= 1'b0;
      tc        <= 8'd0;
      reload    <= ResetReload;
      prev_byte <= 8'h00;
      out_valid <= 1'b0;
      for (int i = 0; i < StoreLen; i++) begin
        store[i] <= 8'h00;
      end
    end else begin
      bc        <= bc_next;
      synced    <= synced_next;
      tc        <= tc_next;
      prev_byte <= prev_byte_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        reload <= cfg_wr_data;
      end
      if (st_we && !(sync_hit && bc == IdxW'(1))) begin
        store[bc] <= rx_byte;
      end
      if (sync_hit) begin
        store[0] <= SyncByte;
        store[1] <= 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    long_sel   <= long_sel_next;
    k          <= k_next;
    sum        <= sum_next;
    want_lo    <= want_lo_next;
    ok_acc     <= ok_acc_next;
    ok_fin     <= ok_fin_next;
    out_byte   <= out_byte_next;
    byte_index <= byte_index_next;
    last_byte  <= last_byte_next;
    long_frame <= long_frame_next;
    frame_ok   <= frame_ok_next;
  end

endmodule
